@@ src/assert_macros.svh @@
// Assertion macros shared by the stencil modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define GCSN_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, checked on every rising edge outside reset.
`define GCSN_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/gcsn_pkg.sv @@
// Types and constants shared by the six-neighbour grid stencil modules.
// No dependencies.
package gcsn_pkg;

    localparam int EXT_W     = 11;
    localparam int NUM_W     = 30;
    localparam int LAYER_W   = 2 * EXT_W;
    localparam int TOTAL_W   = 3 * EXT_W;
    localparam int DIR_W     = 3;
    localparam int ST_W      = 2;
    localparam int NDIR      = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STAGES    = 2 * EXT_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 2'd2;

    localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
    localparam logic [DIR_W-1:0] DIR_MX = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
    localparam logic [DIR_W-1:0] DIR_MY = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_MZ = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [EXT_W-1:0]   ex;
        logic [EXT_W-1:0]   ey;
        logic [EXT_W-1:0]   ez;
        logic [LAYER_W-1:0] layer;
        logic [TOTAL_W-1:0] total;
    } geom_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NDIR-1:0]  mask;
        logic [ST_W-1:0]  status;
    } item_t;

endpackage

@@ src/gcsn_front.sv @@
// Front end: accepts cell numbers, splits them into coordinates with a pipelined
// restoring divider and classifies which face neighbours exist. Uses gcsn_pkg.
`include "assert_macros.svh"

module gcsn_front
    import gcsn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  logic             settle_busy,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [NUM_W-1:0] cell_number,
    input  logic             q_full,
    output logic             push,
    output item_t            push_item
);

    logic             v_reg   [0:STAGES];
    logic             err_reg [0:STAGES];
    logic [NUM_W-1:0] num_reg [0:STAGES];
    logic [NUM_W-1:0] rem_reg [0:STAGES];
    logic [EXT_W-1:0] zq_reg  [0:STAGES];
    logic [EXT_W-1:0] yq_reg  [0:STAGES];

    logic [NUM_W-1:0] rem_next [1:STAGES];
    logic [EXT_W-1:0] zq_next  [1:STAGES];
    logic [EXT_W-1:0] yq_next  [1:STAGES];

    logic             advance;
    logic [EXT_W-1:0] x_c;
    logic [EXT_W:0]   x_inc;
    logic [EXT_W:0]   y_inc;
    logic [EXT_W:0]   z_inc;

    // The whole pipe holds only when its last stage cannot hand over to the queue.
    assign advance  = !(v_reg[STAGES] && q_full);
    assign in_stall = !advance || settle_busy;

    // First EXT_W stages give z = n / layer one bit each, the next EXT_W give y = rem / ex.
    always_comb
    begin
        logic [TOTAL_W-1:0] dvs;
        logic [TOTAL_W-1:0] rem_w;
        logic               ge;
        for (int i = 0; i < STAGES; i++)
        begin
            rem_w = TOTAL_W'(rem_reg[i]);
            if (i < EXT_W)
                dvs = TOTAL_W'(geom.layer) << (EXT_W - 1 - i);
            else
                dvs = TOTAL_W'(geom.ex) << (STAGES - 1 - i);
            ge = (rem_w >= dvs);
            rem_next[i+1] = ge ? NUM_W'(rem_w - dvs) : rem_reg[i];
            zq_next[i+1]  = zq_reg[i];
            yq_next[i+1]  = yq_reg[i];
            if (i < EXT_W)
                zq_next[i+1][EXT_W-1-i] = ge;
            else
                yq_next[i+1][STAGES-1-i] = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid && !settle_busy;
            for (int i = 1; i <= STAGES; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg[0] <= cell_number;
            rem_reg[0] <= cell_number;
            err_reg[0] <= (TOTAL_W'(cell_number) >= geom.total);
            zq_reg[0]  <= '0;
            yq_reg[0]  <= '0;
            for (int i = 1; i <= STAGES; i++)
            begin
                num_reg[i] <= num_reg[i-1];
                err_reg[i] <= err_reg[i-1];
                rem_reg[i] <= rem_next[i];
                zq_reg[i]  <= zq_next[i];
                yq_reg[i]  <= yq_next[i];
            end
        end
    end

    // The final remainder is x; it is below ex, so the low bits hold all of it.
    assign x_c   = rem_reg[STAGES][EXT_W-1:0];
    assign x_inc = {1'b0, x_c} + 1'b1;
    assign y_inc = {1'b0, yq_reg[STAGES]} + 1'b1;
    assign z_inc = {1'b0, zq_reg[STAGES]} + 1'b1;

    always_comb
    begin
        push_item.num = num_reg[STAGES];
        push_item.mask[DIR_PX] = x_inc < {1'b0, geom.ex};
        push_item.mask[DIR_MX] = x_c != '0;
        push_item.mask[DIR_PY] = y_inc < {1'b0, geom.ey};
        push_item.mask[DIR_MY] = yq_reg[STAGES] != '0;
        push_item.mask[DIR_PZ] = z_inc < {1'b0, geom.ez};
        push_item.mask[DIR_MZ] = zq_reg[STAGES] != '0;
        if (err_reg[STAGES])
        begin
            push_item.mask   = '0;
            push_item.status = ST_RANGE;
        end
        else if (push_item.mask == '0)
            push_item.status = ST_NONE;
        else
            push_item.status = ST_OK;
    end

    assign push = v_reg[STAGES] && !q_full;

    `GCSN_ASSERT_IMPL(a_front_ok_has_mask, push && push_item.status == ST_OK, push_item.mask != '0, "ok item without neighbours")
    `GCSN_ASSERT_IMPL(a_front_hold_input, settle_busy, in_stall, "input taken before the products settled")

endmodule

@@ src/gcsn_queue.sv @@
// Short item queue between the classifying front end and the result emitter.
// Uses gcsn_pkg for the item type and depth.
`include "assert_macros.svh"

module gcsn_queue
    import gcsn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t              mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;

    assign full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    `GCSN_ASSERT(a_queue_no_overflow, !(push && full), "push into a full queue")
    `GCSN_ASSERT(a_queue_no_underflow, !(pop && empty), "pop from an empty queue")

endmodule

@@ src/gcsn_back.sv @@
// Back end: walks the neighbour mask of the queue head and emits one result beat
// per cycle, unless out_stall holds it, into a registered output stage. Uses gcsn_pkg.
`include "assert_macros.svh"

module gcsn_back
    import gcsn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  item_t            head,
    input  logic             q_empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [NUM_W-1:0] neighbor_number,
    output logic [DIR_W-1:0] direction,
    output logic [ST_W-1:0]  status,
    output logic             last
);

    logic             cur_valid_reg;
    logic [NUM_W-1:0] cur_num_reg;
    logic [NDIR-1:0]  cur_mask_reg;
    logic [ST_W-1:0]  cur_status_reg;

    logic             out_valid_reg;
    logic [NUM_W-1:0] neighbor_reg;
    logic [DIR_W-1:0] dir_reg;
    logic [ST_W-1:0]  status_reg;
    logic             last_reg;

    logic [NDIR-1:0]    pick;
    logic [NDIR-1:0]    remaining;
    logic [DIR_W-1:0]   dir_c;
    logic               found;
    logic               is_last;
    logic               out_free;
    logic               emit;
    logic               finishing;
    logic               is_minus;
    logic [LAYER_W-1:0] offset;
    logic [NUM_W-1:0]   nb_c;

    // Lowest set bit first gives the order +x, -x, +y, -y, +z, -z.
    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        dir_c = DIR_PX;
        for (int d = 0; d < NDIR; d++)
        begin
            if (cur_mask_reg[d] && !found)
            begin
                pick[d] = 1'b1;
                found   = 1'b1;
                dir_c   = DIR_W'(d);
            end
        end
    end

    assign remaining = cur_mask_reg & ~pick;
    assign is_last   = (cur_status_reg != ST_OK) || (remaining == '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = cur_valid_reg && out_free;
    assign finishing = emit && is_last;
    assign pop       = (!cur_valid_reg || finishing) && !q_empty;

    always_comb
    begin
        case (dir_c)
            DIR_PX, DIR_MX: offset = LAYER_W'(1);
            DIR_PY, DIR_MY: offset = LAYER_W'(geom.ex);
            default:        offset = geom.layer;
        endcase
    end

    assign is_minus = (dir_c == DIR_MX) || (dir_c == DIR_MY) || (dir_c == DIR_MZ);
    assign nb_c     = is_minus ? cur_num_reg - NUM_W'(offset) : cur_num_reg + NUM_W'(offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (finishing)
                cur_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_num_reg    <= head.num;
            cur_mask_reg   <= head.mask;
            cur_status_reg <= head.status;
        end
        else if (emit)
            cur_mask_reg <= remaining;

        if (emit)
        begin
            if (cur_status_reg == ST_OK)
            begin
                neighbor_reg <= nb_c;
                dir_reg      <= dir_c;
            end
            else
            begin
                neighbor_reg <= '0;
                dir_reg      <= DIR_PX;
            end
            status_reg <= cur_status_reg;
            last_reg   <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign neighbor_number = neighbor_reg;
    assign direction       = dir_reg;
    assign status          = status_reg;
    assign last            = last_reg;

    `GCSN_ASSERT_IMPL(a_back_flag_single, out_valid_reg && status_reg != ST_OK, last_reg && neighbor_reg == '0, "status beat not single or not zeroed")
    `GCSN_ASSERT_IMPL(a_back_ok_mask, cur_valid_reg && cur_status_reg == ST_OK && !$past(emit), cur_mask_reg != '0, "fresh ok item with empty mask")

endmodule

@@ src/grid_cell_six_neighbors.sv @@
// Six-neighbour stencil on a 3D grid: a linear cell number goes in, the linear numbers
// of its face neighbours inside the grid come out, one result beat each, order +x, -x,
// +y, -y, +z, -z, with last on the final beat. An item gives one beat per result, 1 to
// 6, and the emitter gives one beat per cycle unless out_stall holds it; the front end
// divider takes a new cell number every cycle unless in_stall is set, and passes it
// through its registered stages to the queue, and a four-entry queue lets it run ahead
// of the emitter. After an extent write the input is held while the layer and cell-count
// products are formed. Written extents of 0 read as 1, above MAX_EXTENT as MAX_EXTENT.

module grid_cell_six_neighbors
    import gcsn_pkg::*;
#(
    parameter int MAX_EXTENT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EXT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_W-1:0]     cell_number,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_W-1:0]     neighbor_number,
    output logic [DIR_W-1:0]     direction,
    output logic [ST_W-1:0]      status,
    output logic                 last
);

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] r;
        if (v == '0)
            r = EXT_W'(1);
        else if (int'(v) > MAX_EXTENT)
            r = EXT_W'(MAX_EXTENT);
        else
            r = v;
        return r;
    endfunction

    logic [EXT_W-1:0]   ex_reg;
    logic [EXT_W-1:0]   ey_reg;
    logic [EXT_W-1:0]   ez_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [1:0]         settle_reg;
    logic               cfg_write;
    geom_t              geom;

    logic  push;
    item_t push_item;
    logic  pop;
    item_t head;
    logic  q_full;
    logic  q_empty;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_reg     <= EXT_W'(1);
            ey_reg     <= EXT_W'(1);
            ez_reg     <= EXT_W'(1);
            layer_reg  <= LAYER_W'(1);
            total_reg  <= TOTAL_W'(1);
            settle_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_EXTENT_X: ex_reg <= clamp_extent(cfg_data);
                    CFG_EXTENT_Y: ey_reg <= clamp_extent(cfg_data);
                    CFG_EXTENT_Z: ez_reg <= clamp_extent(cfg_data);
                    default: ;
                endcase
                settle_reg <= SETTLE_CYCLES;
            end
            else if (settle_reg != '0)
                settle_reg <= settle_reg - 1'b1;
            layer_reg <= LAYER_W'(ex_reg) * LAYER_W'(ey_reg);
            total_reg <= TOTAL_W'(layer_reg) * TOTAL_W'(ez_reg);
        end
    end

    always_comb
    begin
        geom.ex    = ex_reg;
        geom.ey    = ey_reg;
        geom.ez    = ez_reg;
        geom.layer = layer_reg;
        geom.total = total_reg;
    end

    gcsn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .settle_busy (settle_reg != '0),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_number (cell_number),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    gcsn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    gcsn_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .geom            (geom),
        .head            (head),
        .q_empty         (q_empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .neighbor_number (neighbor_number),
        .direction       (direction),
        .status          (status),
        .last            (last)
    );

endmodule
